[rtl/ccf_grant_segmenter_defines.svh]
// ----------------------------------------------------------------------------
// Segmenter assertion macros
// Clocked assertion wrappers used by the segmenter RTL.
// ----------------------------------------------------------------------------
`ifndef CCF_GRANT_SEGMENTER_DEFINES_SVH
`define CCF_GRANT_SEGMENTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// condition implies consequence in the same cycle
`define CGS_ASSERT_IMPL(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |-> (cons)) \
        else $error(msg);
// condition implies consequence in the next cycle
`define CGS_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (cons)) \
        else $error(msg);
`else
`define CGS_ASSERT_IMPL(lbl, cond, cons, msg)
`define CGS_ASSERT_NEXT(lbl, cond, cons, msg)
`endif

`endif

[rtl/cgs_pkg.sv]
// ----------------------------------------------------------------------------
// Segmenter package
// Shared types and constants of the grant segmenter.
// ----------------------------------------------------------------------------
package cgs_pkg;

    // most segments produced by one input beat
    localparam int MAX_RESULTS = 16;

    // actions
    localparam logic [1:0] ACT_PACKET = 2'd0;
    localparam logic [1:0] ACT_GRANT  = 2'd1;
    localparam logic [1:0] ACT_PIGGY  = 2'd2;

    // configuration register indexes
    localparam logic CFG_SFID = 1'b0;
    localparam logic CFG_UNIT = 1'b1;

    // grant entry
    typedef struct packed {
        logic [15:0] size;
        logic [31:0] deadline;
        logic [7:0]  chan;
    } t_grant;

    // segment descriptor
    typedef struct packed {
        logic [12:0] seq;
        logic        pfi;
        logic [15:0] moff;
        logic [15:0] plen;
        logic [15:0] req;
        logic [7:0]  chan;
        logic [31:0] send;
        logic [4:0]  done;
    } t_seg;

endpackage

[rtl/ccf_grant_segmenter.sv]
// ----------------------------------------------------------------------------
// Grant segmenter
// Packet-length FIFO, deadline-sorted grant queue and piggyback accumulator;
// emits one segment descriptor per grant used.
// ----------------------------------------------------------------------------
// One input beat is taken only while the block is idle. A grant insert walks
// the sorted grant queue from its tail, moving one entry per read and write
// of the grant memory. The drain then drops each expired grant, places packet
// pieces into each grant used, divides the piggyback request on the last
// queued grant, and delivers each segment, held by any output stall.
// Segments are held one deep so that the final one of a beat can carry last.
// service_flow_id is accepted and takes no part in any output.
module ccf_grant_segmenter #(
    parameter int PACKET_DEPTH = 16,
    parameter int GRANT_DEPTH  = 16,
    parameter int HEADER_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [13:0] i_packet_length,
    input  logic [15:0] i_grant_size,
    input  logic [31:0] i_grant_deadline,
    input  logic [7:0]  i_grant_channel,
    input  logic [23:0] i_request_bytes,
    input  logic [31:0] i_now_time,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [12:0] o_sequence_res,
    output logic        o_pfi,
    output logic [15:0] o_mac_offset,
    output logic [15:0] o_payload_length,
    output logic [15:0] o_request,
    output logic [7:0]  o_channel,
    output logic [31:0] o_send_time,
    output logic [4:0]  o_packets_finished,
    output logic        o_last
);
`include "ccf_grant_segmenter_defines.svh"

    localparam int PIW = (PACKET_DEPTH > 1) ? $clog2(PACKET_DEPTH) : 1;
    localparam int PCW = $clog2(PACKET_DEPTH + 1);
    localparam int GIW = (GRANT_DEPTH > 1) ? $clog2(GRANT_DEPTH) : 1;
    localparam int GCW = $clog2(GRANT_DEPTH + 1);
    localparam int RCW = $clog2(cgs_pkg::MAX_RESULTS + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INS_RD = 4'd1;
    localparam logic [3:0] S_INS_CP = 4'd2;
    localparam logic [3:0] S_CHK    = 4'd3;
    localparam logic [3:0] S_GNT    = 4'd4;
    localparam logic [3:0] S_FLOOP  = 4'd5;
    localparam logic [3:0] S_FSTEP  = 4'd6;
    localparam logic [3:0] S_SEG    = 4'd7;
    localparam logic [3:0] S_DIV    = 4'd8;
    localparam logic [3:0] S_SEGOUT = 4'd9;
    localparam logic [3:0] S_EMIT   = 4'd10;

    // control state
    logic [3:0]     r_state, r_ret;
    logic [PIW-1:0] r_phead, r_ptail;
    logic [PCW-1:0] r_pcount;
    logic [13:0]    r_hoff;
    logic [GIW-1:0] r_ghead;
    logic [GCW-1:0] r_gcount, r_pos;
    logic [12:0]    r_seq;
    logic [23:0]    r_piggy;
    logic [7:0]     r_unit;
    logic [RCW-1:0] r_nres;
    logic           r_pend_v, r_out_v, r_out_last;

    // working registers
    cgs_pkg::t_grant r_newg, r_curg, r_grd;
    cgs_pkg::t_seg   r_pend, r_out, r_seg;
    logic [31:0]     r_now;
    logic [15:0]     r_cap;
    logic            r_is_last;
    logic [13:0]     r_prd;
    logic [8:0]      r_rem;
    logic [23:0]     r_dq;
    logic [4:0]      r_dcnt;

    // memories
    logic [13:0]     pmem [PACKET_DEPTH];
    cgs_pkg::t_grant gmem [GRANT_DEPTH];

    // logical grant position to memory address
    function automatic logic [GIW-1:0] gphys(input logic [GIW-1:0] head,
                                             input logic [GCW-1:0] lpos);
        logic [GIW+1:0] s;
        s = (GIW+2)'(head) + (GIW+2)'(lpos);
        if (s >= (GIW+2)'(GRANT_DEPTH)) s = s - (GIW+2)'(GRANT_DEPTH);
        return s[GIW-1:0];
    endfunction

    logic            accept;
    logic [GIW-1:0]  g_raddr, g_waddr;
    logic            g_we;
    cgs_pkg::t_grant g_wdata;
    logic [13:0]     f_rem;
    logic [15:0]     f_room, f_take;
    logic [14:0]     f_hsum;
    logic [24:0]     pig_sum;
    logic [8:0]      d_try;
    logic [9:0]      d_diff;
    logic [7:0]      d_unit;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    // grant memory port control
    always_comb begin
        g_raddr = (r_state == S_INS_RD) ? gphys(r_ghead, r_pos - GCW'(1)) : r_ghead;
        g_waddr = gphys(r_ghead, r_pos);
        g_we    = 1'b0;
        g_wdata = r_newg;
        if (r_state == S_INS_RD && r_pos == '0) begin
            g_we = 1'b1;
        end else if (r_state == S_INS_CP) begin
            g_we = 1'b1;
            if (r_grd.deadline > r_newg.deadline) g_wdata = r_grd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (g_we) gmem[g_waddr] <= g_wdata;
        r_grd <= gmem[g_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_action == cgs_pkg::ACT_PACKET && i_packet_length != '0 &&
            r_pcount < PCW'(PACKET_DEPTH))
            pmem[r_ptail] <= i_packet_length;
        r_prd <= pmem[r_phead];
    end

    // fill step arithmetic
    always_comb begin
        f_rem  = (r_prd > r_hoff) ? r_prd - r_hoff : '0;
        f_room = r_cap - r_seg.plen;
        f_take = (16'(f_rem) < f_room) ? 16'(f_rem) : f_room;
        f_hsum = 15'(r_hoff) + f_take[14:0];
        pig_sum = 25'(r_piggy) + 25'(i_request_bytes);
        d_unit = (r_unit == '0) ? 8'd1 : r_unit;
        d_try  = {r_rem[7:0], r_dq[23]};
        d_diff = 10'(d_try) - 10'(d_unit);
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ret    <= S_IDLE;
            r_phead  <= '0;
            r_ptail  <= '0;
            r_pcount <= '0;
            r_hoff   <= '0;
            r_ghead  <= '0;
            r_gcount <= '0;
            r_pos    <= '0;
            r_seq    <= '0;
            r_piggy  <= '0;
            r_unit   <= 8'd1;
            r_nres   <= '0;
            r_dcnt   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
            r_out_last <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_index == cgs_pkg::CFG_UNIT) r_unit <= i_cfg_data;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_now  <= i_now_time;
                        r_nres <= '0;
                        r_newg <= '{size: i_grant_size, deadline: i_grant_deadline,
                                    chan: i_grant_channel};
                        r_pos  <= r_gcount;
                        case (i_action)
                            cgs_pkg::ACT_PACKET: begin
                                if (i_packet_length != '0 &&
                                    r_pcount < PCW'(PACKET_DEPTH)) begin
                                    r_pcount <= r_pcount + PCW'(1);
                                    r_ptail  <= (r_ptail == PIW'(PACKET_DEPTH - 1)) ?
                                                '0 : r_ptail + PIW'(1);
                                end
                                r_state <= S_CHK;
                            end
                            cgs_pkg::ACT_GRANT: begin
                                r_state <= (r_gcount < GCW'(GRANT_DEPTH)) ?
                                           S_INS_RD : S_CHK;
                            end
                            cgs_pkg::ACT_PIGGY: begin
                                r_piggy <= pig_sum[24] ? 24'hFFFFFF : pig_sum[23:0];
                                r_state <= S_CHK;
                            end
                            default: r_state <= S_CHK;
                        endcase
                    end
                end
                // sorted insert, one entry moved per visit
                S_INS_RD: begin
                    if (r_pos == '0) begin
                        r_gcount <= r_gcount + GCW'(1);
                        r_state  <= S_CHK;
                    end else begin
                        r_state <= S_INS_CP;
                    end
                end
                S_INS_CP: begin
                    if (r_grd.deadline > r_newg.deadline) begin
                        r_pos   <= r_pos - GCW'(1);
                        r_state <= S_INS_RD;
                    end else begin
                        r_gcount <= r_gcount + GCW'(1);
                        r_state  <= S_CHK;
                    end
                end
                // next grant or wrap up the beat
                S_CHK: begin
                    if (r_gcount != '0 && r_pcount != '0 &&
                        r_nres < RCW'(cgs_pkg::MAX_RESULTS)) begin
                        r_state <= S_GNT;
                    end else if (r_pend_v) begin
                        r_out      <= r_pend;
                        r_out_last <= 1'b1;
                        r_out_v    <= 1'b1;
                        r_pend_v   <= 1'b0;
                        r_ret      <= S_IDLE;
                        r_state    <= S_EMIT;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_GNT: begin
                    if (r_now > r_grd.deadline) begin
                        r_ghead  <= (r_ghead == GIW'(GRANT_DEPTH - 1)) ?
                                    '0 : r_ghead + GIW'(1);
                        r_gcount <= r_gcount - GCW'(1);
                        r_state  <= S_CHK;
                    end else begin
                        r_curg    <= r_grd;
                        r_is_last <= (r_gcount == GCW'(1));
                        r_cap     <= (r_grd.size > 16'(HEADER_BYTES)) ?
                                     r_grd.size - 16'(HEADER_BYTES) : '0;
                        r_seg     <= '0;
                        r_state   <= S_FLOOP;
                    end
                end
                S_FLOOP: begin
                    r_state <= (r_seg.plen < r_cap && r_pcount != '0) ? S_FSTEP : S_SEG;
                end
                // place one packet piece
                S_FSTEP: begin
                    if (r_hoff == '0 && !r_seg.pfi) begin
                        r_seg.pfi  <= 1'b1;
                        r_seg.moff <= r_seg.plen;
                    end
                    r_seg.plen <= r_seg.plen + f_take;
                    if (f_hsum >= 15'(r_prd)) begin
                        r_hoff   <= '0;
                        r_pcount <= r_pcount - PCW'(1);
                        r_phead  <= (r_phead == PIW'(PACKET_DEPTH - 1)) ?
                                    '0 : r_phead + PIW'(1);
                        r_seg.done <= r_seg.done + 5'd1;
                    end else begin
                        r_hoff <= f_hsum[13:0];
                    end
                    r_state <= S_FLOOP;
                end
                S_SEG: begin
                    r_ghead  <= (r_ghead == GIW'(GRANT_DEPTH - 1)) ? '0 : r_ghead + GIW'(1);
                    r_gcount <= r_gcount - GCW'(1);
                    r_seg.chan <= r_curg.chan;
                    r_seg.send <= r_curg.deadline;
                    if (r_seg.plen == '0) begin
                        r_state <= S_CHK;
                    end else if (r_piggy != '0 && r_is_last) begin
                        r_rem   <= '0;
                        r_dq    <= r_piggy;
                        r_dcnt  <= '0;
                        r_piggy <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_SEGOUT;
                    end
                end
                // restoring divide, one quotient bit per cycle
                S_DIV: begin
                    if (!d_diff[9]) begin
                        r_rem <= d_diff[8:0];
                        r_dq  <= {r_dq[22:0], 1'b1};
                    end else begin
                        r_rem <= d_try;
                        r_dq  <= {r_dq[22:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt + 5'd1;
                    if (r_dcnt == 5'd23) r_state <= S_SEGOUT;
                end
                // flush the held segment, then hold this one
                S_SEGOUT: begin
                    if (r_pend_v) begin
                        r_out      <= r_pend;
                        r_out_last <= 1'b0;
                        r_out_v    <= 1'b1;
                        r_pend_v   <= 1'b0;
                        r_ret      <= S_SEGOUT;
                        r_state    <= S_EMIT;
                    end else begin
                        r_pend <= '{seq: r_seq, pfi: r_seg.pfi, moff: r_seg.moff,
                                    plen: r_seg.plen,
                                    req: (r_piggy == '0 && r_is_last && r_dcnt == 5'd24) ?
                                         ((r_dq[23:16] != '0) ? 16'hFFFF : r_dq[15:0]) :
                                         16'd0,
                                    chan: r_seg.chan, send: r_seg.send,
                                    done: r_seg.done};
                        r_pend_v   <= 1'b1;
                        r_seq      <= r_seq + 13'd1;
                        r_nres     <= r_nres + RCW'(1);
                        r_dcnt     <= '0;
                        r_state    <= S_CHK;
                    end
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        r_out_v <= 1'b0;
                        r_state <= r_ret;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid        = r_out_v;
    assign o_sequence_res     = r_out.seq;
    assign o_pfi              = r_out.pfi;
    assign o_mac_offset       = r_out.moff;
    assign o_payload_length   = r_out.plen;
    assign o_request          = r_out.req;
    assign o_channel          = r_out.chan;
    assign o_send_time        = r_out.send;
    assign o_packets_finished = r_out.done;
    assign o_last             = r_out_last;

    `CGS_ASSERT_IMPL(a_idle_no_out, r_state == S_IDLE, !r_out_v, "result pending while idle")
    `CGS_ASSERT_IMPL(a_pcount, 1'b1, r_pcount <= PCW'(PACKET_DEPTH), "packet count overflow")
    `CGS_ASSERT_IMPL(a_gcount, 1'b1, r_gcount <= GCW'(GRANT_DEPTH), "grant count overflow")
    `CGS_ASSERT_NEXT(a_emit_done, r_state == S_EMIT && i_out_ready,
                     !r_out_v, "segment not retired after beat")

endmodule

[test/cgs_segment_checker.sv]
// ----------------------------------------------------------------------------
// Segment descriptor checker
// Watches the config port and both beat channels of the grant segmenter. It
// predicts the segment descriptors of every accepted input beat and compares
// each delivered descriptor with the oldest one predicted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cgs_segment_checker #(
    parameter int PACKET_DEPTH = 16,
    parameter int GRANT_DEPTH  = 16,
    parameter int HEADER_BYTES = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_action,
    input  logic [13:0] i_packet_length,
    input  logic [15:0] i_grant_size,
    input  logic [31:0] i_grant_deadline,
    input  logic [7:0]  i_grant_channel,
    input  logic [23:0] i_request_bytes,
    input  logic [31:0] i_now_time,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [12:0] i_sequence_res,
    input  logic        i_pfi,
    input  logic [15:0] i_mac_offset,
    input  logic [15:0] i_payload_length,
    input  logic [15:0] i_request,
    input  logic [7:0]  i_channel,
    input  logic [31:0] i_send_time,
    input  logic [4:0]  i_packets_finished,
    input  logic        i_last,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_segments
);

    typedef struct {
        cgs_pkg::t_seg seg;
        logic last;
    } t_expected_seg;

    t_expected_seg expected_segs[$];

    // predictor copy of the block state
    logic [7:0]  sfid_copy;
    logic [7:0]  unit_copy;
    logic [13:0] pkt_len_q[PACKET_DEPTH];
    int          pkt_head;
    int          pkt_cnt;
    int          head_off;
    cgs_pkg::t_grant grant_q[GRANT_DEPTH];
    int          grant_cnt;
    logic [12:0] seq_cnt;
    logic [23:0] piggy_acc;

    int fail_count;
    int segments;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_segs.size();
    assign o_segments   = segments;

    task automatic report(input string what, input longint got, input longint exp);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
        fail_count++;
    endtask

    // one input beat: queue updates, then drain grants into segments
    task automatic segment_beat(input logic [1:0] act, input logic [13:0] plen,
                                input logic [15:0] gsize, input logic [31:0] gdead,
                                input logic [7:0] gchan, input logic [23:0] rbytes,
                                input logic [31:0] now);
        t_expected_seg made[$];
        t_expected_seg e;
        cgs_pkg::t_grant g;
        int pos, cap, used, pfi, moff, done, req, len, rem, take, unit;
        logic is_last;
        longint sum;
        if (act == cgs_pkg::ACT_PACKET) begin
            if (plen != 0 && pkt_cnt < PACKET_DEPTH) begin
                pkt_len_q[(pkt_head + pkt_cnt) % PACKET_DEPTH] = plen;
                pkt_cnt++;
            end
        end else if (act == cgs_pkg::ACT_GRANT) begin
            if (grant_cnt < GRANT_DEPTH) begin
                pos = grant_cnt;
                // equal deadlines keep arrival order
                while (pos > 0 && grant_q[pos-1].deadline > gdead) begin
                    grant_q[pos] = grant_q[pos-1];
                    pos--;
                end
                grant_q[pos] = '{size: gsize, deadline: gdead, chan: gchan};
                grant_cnt++;
            end
        end else if (act == cgs_pkg::ACT_PIGGY) begin
            sum = longint'(piggy_acc) + longint'(rbytes);
            piggy_acc = (sum > 24'hFFFFFF) ? 24'hFFFFFF : sum[23:0];
        end

        while (grant_cnt > 0 && pkt_cnt > 0 && made.size() < cgs_pkg::MAX_RESULTS) begin
            g = grant_q[0];
            is_last = (grant_cnt == 1);
            for (int i = 1; i < grant_cnt; i++) grant_q[i-1] = grant_q[i];
            grant_cnt--;
            if (now > g.deadline) continue;
            cap = (g.size > HEADER_BYTES) ? int'(g.size) - HEADER_BYTES : 0;
            used = 0; pfi = 0; moff = 0; done = 0; req = 0;
            while (used < cap && pkt_cnt > 0) begin
                len = pkt_len_q[pkt_head];
                rem = (len > head_off) ? len - head_off : 0;
                if (head_off == 0 && pfi == 0) begin
                    pfi = 1;
                    moff = used;
                end
                take = (rem < cap - used) ? rem : cap - used;
                used += take;
                head_off += take;
                if (head_off >= len) begin
                    pkt_head = (pkt_head + 1) % PACKET_DEPTH;
                    pkt_cnt--;
                    head_off = 0;
                    done++;
                end
            end
            if (used == 0) continue;
            // request rides only on the last queued grant
            if (piggy_acc > 0 && is_last) begin
                unit = (unit_copy == 0) ? 1 : int'(unit_copy);
                req = int'(piggy_acc) / unit;
                if (req > 16'hFFFF) req = 16'hFFFF;
                piggy_acc = '0;
            end
            e.seg.seq  = seq_cnt;
            e.seg.pfi  = pfi[0];
            e.seg.moff = moff[15:0];
            e.seg.plen = used[15:0];
            e.seg.req  = req[15:0];
            e.seg.chan = g.chan;
            e.seg.send = g.deadline;
            e.seg.done = done[4:0];
            e.last     = 1'b0;
            made.insert(made.size(), e);
            seq_cnt = seq_cnt + 13'd1;
        end
        if (made.size() > 0) made[made.size()-1].last = 1'b1;
        foreach (made[i]) expected_segs.insert(expected_segs.size(), made[i]);
    endtask

    always @(posedge i_clk) begin
        t_expected_seg e;
        if (!i_rst_n) begin
            sfid_copy <= 8'd0;
            unit_copy = 8'd1;
            pkt_head  = 0;
            pkt_cnt   = 0;
            head_off  = 0;
            grant_cnt = 0;
            seq_cnt   = '0;
            piggy_acc = '0;
            expected_segs.delete();
        end else begin
            // config write
            if (i_cfg_we) begin
                if (i_cfg_index == cgs_pkg::CFG_SFID) sfid_copy <= i_cfg_data;
                else unit_copy = i_cfg_data;
            end
            // delivered segment
            if (i_out_valid && i_out_ready) begin
                segments++;
                if (expected_segs.size() == 0) begin
                    report("unexpected segment, seq", i_sequence_res, -1);
                end else begin
                    e = expected_segs.pop_front();
                    if (i_sequence_res !== e.seg.seq)
                        report("sequence_res", i_sequence_res, e.seg.seq);
                    if (i_pfi !== e.seg.pfi) report("pfi", i_pfi, e.seg.pfi);
                    if (i_mac_offset !== e.seg.moff)
                        report("mac_offset", i_mac_offset, e.seg.moff);
                    if (i_payload_length !== e.seg.plen)
                        report("payload_length", i_payload_length, e.seg.plen);
                    if (i_request !== e.seg.req) report("request", i_request, e.seg.req);
                    if (i_channel !== e.seg.chan) report("channel", i_channel, e.seg.chan);
                    if (i_send_time !== e.seg.send)
                        report("send_time", i_send_time, e.seg.send);
                    if (i_packets_finished !== e.seg.done)
                        report("packets_finished", i_packets_finished, e.seg.done);
                    if (i_last !== e.last) report("last", i_last, e.last);
                end
            end
            // accepted input beat
            if (i_in_valid && i_in_ready)
                segment_beat(i_action, i_packet_length, i_grant_size, i_grant_deadline,
                             i_grant_channel, i_request_bytes, i_now_time);
        end
    end

    initial begin
        fail_count = 0;
        segments   = 0;
    end

endmodule

[test/tb_top.sv]
// ----------------------------------------------------------------------------
// Grant segmenter testbench
// Drives directed and random packet, grant and piggyback beats through
// several register settings with random gaps and stalls on both channels;
// the checker predicts and compares every segment descriptor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    localparam logic [1:0] ACT_NONE = 2'd3;   // unknown action
    localparam int IDLE_CYCLES = 600;         // settling wait after the last segment
    localparam int STALL_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int NUM_PHASES = 5;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_action;
    logic [13:0] i_packet_length;
    logic [15:0] i_grant_size;
    logic [31:0] i_grant_deadline;
    logic [7:0]  i_grant_channel;
    logic [23:0] i_request_bytes;
    logic [31:0] i_now_time;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [12:0] o_sequence_res;
    logic        o_pfi;
    logic [15:0] o_mac_offset;
    logic [15:0] o_payload_length;
    logic [15:0] o_request;
    logic [7:0]  o_channel;
    logic [31:0] o_send_time;
    logic [4:0]  o_packets_finished;
    logic        o_last;

    int fail_count, pending, segments;
    int beats_sent;
    int idle_cycles = 0;
    logic hold_output;
    logic [31:0] cur_now;

    ccf_grant_segmenter dut (.*);

    cgs_segment_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid, .i_in_ready(o_in_ready), .i_action, .i_packet_length,
        .i_grant_size, .i_grant_deadline, .i_grant_channel, .i_request_bytes,
        .i_now_time, .i_out_valid(o_out_valid), .i_out_ready,
        .i_sequence_res(o_sequence_res), .i_pfi(o_pfi), .i_mac_offset(o_mac_offset),
        .i_payload_length(o_payload_length), .i_request(o_request),
        .i_channel(o_channel), .i_send_time(o_send_time),
        .i_packets_finished(o_packets_finished), .i_last(o_last),
        .o_fail_count(fail_count), .o_pending(pending), .o_segments(segments)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: cycles with no beat on any port
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired at %0t", $realtime);
            $display("Verification failed");
            $finish;
        end
    end

    // receiver: random wait per beat, one long hold when asked
    initial begin
        int w;
        bit hold_done;
        hold_done = 1'b0;
        i_out_ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_output && !hold_done) begin
                i_out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge i_clk);
                hold_done = 1'b1;
            end
            w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
            if (w > 0) begin
                i_out_ready <= 1'b0;
                repeat (w) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send_beat(input logic [1:0] act, input logic [13:0] plen,
                             input logic [15:0] gsize, input logic [31:0] gdead,
                             input logic [7:0] gchan, input logic [23:0] rbytes,
                             input logic [31:0] now);
        int g;
        i_action         <= act;
        i_packet_length  <= plen;
        i_grant_size     <= gsize;
        i_grant_deadline <= gdead;
        i_grant_channel  <= gchan;
        i_request_bytes  <= rbytes;
        i_now_time       <= now;
        i_in_valid       <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
        g = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic write_cfg(input logic idx, input logic [7:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // wait until every predicted segment is out and the block has settled
    task automatic drain_all();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_packet(input logic [13:0] plen);
        send_beat(cgs_pkg::ACT_PACKET, plen, 16'($urandom), $urandom, 8'($urandom),
                  24'($urandom), cur_now);
    endtask

    task automatic send_grant(input logic [15:0] gsize, input logic [31:0] gdead);
        send_beat(cgs_pkg::ACT_GRANT, 14'($urandom), gsize, gdead, 8'($urandom),
                  24'($urandom), cur_now);
    endtask

    // random beat, mostly well-formed with a running time base
    task automatic random_beat();
        logic [13:0] plen;
        logic [15:0] gsize;
        logic [31:0] gdead;
        logic [31:0] now;
        logic [23:0] rb;
        int sel;
        cur_now = cur_now + $urandom_range(0, 40);
        now = ($urandom_range(0, 40) == 0) ? $urandom : cur_now;
        plen = ($urandom_range(0, 3) == 0) ? 14'($urandom) : 14'($urandom_range(1, 300));
        gsize = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
        sel = $urandom_range(0, 9);
        if (sel == 0) gdead = $urandom;
        else if (sel == 1) gdead = cur_now - $urandom_range(1, 50);
        else gdead = cur_now + $urandom_range(0, 300);
        rb = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'($urandom_range(0, 5000));
        sel = $urandom_range(0, 19);
        if (sel < 8)
            send_beat(cgs_pkg::ACT_PACKET, plen, 16'($urandom), $urandom, 8'($urandom),
                      24'($urandom), now);
        else if (sel < 15)
            send_beat(cgs_pkg::ACT_GRANT, 14'($urandom), gsize, gdead, 8'($urandom),
                      24'($urandom), now);
        else if (sel < 19)
            send_beat(cgs_pkg::ACT_PIGGY, 14'($urandom), 16'($urandom), $urandom,
                      8'($urandom), rb, now);
        else
            send_beat(ACT_NONE, plen, gsize, gdead, 8'($urandom), rb, now);
    endtask

    // stimulus
    initial begin
        logic [7:0] sfid_set[NUM_PHASES] = '{8'd0, 8'd255, 8'h5A, 8'd17, 8'd128};
        logic [7:0] unit_set[NUM_PHASES] = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd100};
        int n;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0; i_cfg_index = 1'b0; i_cfg_data = '0;
        i_in_valid = 1'b0; i_action = '0; i_packet_length = '0;
        i_grant_size = '0; i_grant_deadline = '0; i_grant_channel = '0;
        i_request_bytes = '0; i_now_time = '0;
        hold_output = 1'b0;
        beats_sent = 0;
        cur_now = 32'd1000;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            write_cfg(cgs_pkg::CFG_SFID, sfid_set[ph]);
            write_cfg(cgs_pkg::CFG_UNIT, unit_set[ph]);
            if (ph == 0) begin
                // directed: field extremes and special cases
                send_packet(14'd1);
                send_packet(14'd0);                        // zero length ignored
                send_packet(14'd16383);
                send_beat(cgs_pkg::ACT_PIGGY, '0, '0, '0, '0, 24'hFFFFFF, cur_now);
                send_beat(cgs_pkg::ACT_PIGGY, '0, '0, '0, '0, 24'hFFFFFF, cur_now); // saturates
                send_beat(cgs_pkg::ACT_PIGGY, '0, '0, '0, '0, 24'd0, cur_now);
                send_grant(16'd0, cur_now + 10);           // no payload room
                send_grant(16'd8, cur_now + 10);           // header only
                send_grant(16'd9, cur_now + 5);
                send_grant(16'd100, cur_now - 1);          // expired
                send_beat(cgs_pkg::ACT_GRANT, '0, 16'd50, cur_now + 20, 8'hFF, '0, cur_now);
                send_beat(cgs_pkg::ACT_GRANT, '0, 16'd50, cur_now + 20, 8'h00, '0,
                          cur_now);                        // tie
                send_beat(cgs_pkg::ACT_GRANT, '1, 16'hFFFF, 32'hFFFFFFFF, 8'hA5, '1, 32'd0);
                send_beat(ACT_NONE, '1, '1, '1, '1, '1, cur_now); // unknown action
                for (int i = 0; i < 10; i++) send_packet(14'($urandom_range(1, 20)));
                send_beat(cgs_pkg::ACT_GRANT, '0, 16'd2000, cur_now + 50, 8'd7, '0,
                          32'hFFFFFFFF);
                drain_all();
            end
            if (ph == 1) hold_output = 1'b1;   // long receiver stall, input fills up
            n = 0;
            while (n < 70) begin
                case ($urandom_range(0, 5))
                    0: begin
                        // fill the packet queue past full, then one big grant
                        for (int i = 0; i < 18; i++) send_packet(14'($urandom_range(1, 40)));
                        send_grant(16'($urandom_range(300, 1200)), cur_now + 100);
                        n += 19;
                    end
                    1: begin
                        // fill the grant queue past full, then packets
                        for (int i = 0; i < 18; i++)
                            send_grant(16'($urandom_range(0, 120)),
                                       cur_now + $urandom_range(0, 400));
                        for (int i = 0; i < 3; i++) send_packet(14'($urandom_range(1, 900)));
                        n += 21;
                    end
                    default: begin
                        random_beat();
                        n++;
                    end
                endcase
            end
            drain_all();   // sender pause until everything is out
        end
        i_in_valid <= 1'b0;
        drain_all();

        $display("Sent %0d beats over %0d register settings, %0d segments checked",
                 beats_sent, NUM_PHASES, segments);
        $display("Covered queue overflow, expiry, ties, saturation and long output stalls");
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl
rtl/cgs_pkg.sv
rtl/ccf_grant_segmenter.sv
test/cgs_segment_checker.sv
test/tb_top.sv
